### hdl/mtep_pkg.sv
// Package for the MIDI track event parser.
// Holds the parse phase and record kind types and the byte codes of the track format.
// No dependencies.
package mtep_pkg;

  localparam int unsigned MaxQuantityBytes = 4;
  localparam int unsigned QuantityWidth = 28;
  localparam int unsigned TempoWidth = 32;

  localparam logic [7:0] DataMask = 8'h7F;
  localparam logic [7:0] StatusMetaPrefix = 8'hFF;
  localparam logic [7:0] MetaEndOfTrack = 8'h2F;
  localparam logic [7:0] MetaTempo = 8'h51;
  localparam logic [7:0] MetaTimeSignature = 8'h58;
  localparam logic [7:0] ChannelStatusLow = 8'h80;
  localparam logic [7:0] ChannelStatusHigh = 8'hEF;
  localparam logic [7:0] OneDataLow = 8'hC0;
  localparam logic [7:0] OneDataHigh = 8'hDF;

  typedef enum logic [2:0] {
    PH_DELTA = 3'd0,
    PH_STATUS = 3'd1,
    PH_DATA1 = 3'd2,
    PH_DATA2 = 3'd3,
    PH_MTYPE = 3'd4,
    PH_MLEN = 3'd5,
    PH_MBODY = 3'd6,
    PH_DONE = 3'd7
  } parse_phase_e;

  typedef enum logic [2:0] {
    EV_CHANNEL = 3'd0,
    EV_TEMPO = 3'd1,
    EV_TIME_SIG = 3'd2,
    EV_OTHER_META = 3'd3,
    EV_END_OF_TRACK = 3'd4,
    EV_UNKNOWN_STATUS = 3'd5,
    EV_LENGTH_OVERFLOW = 3'd6
  } event_kind_e;

  function automatic logic is_one_data(input logic [7:0] status);
    return (status >= OneDataLow) && (status <= OneDataHigh);
  endfunction

endpackage

### hdl/midi_track_event_parser.sv
// MIDI track event parser: top level with stream ports on both sides.
// Depends on mtep_pkg for phase and kind types and the track byte codes.
// One byte is accepted per cycle unless the output stalls; a byte goes through an input
// register, a short state update and a result register, which holds the record of the byte
// that completes its event. Delta times and meta lengths are variable-length quantities of
// at most MAX_QUANTITY_BYTES bytes; a longer one gives a length overflow record. Tempo and
// time signature survive a track start, everything else is cleared by it. After an
// end-of-track meta the parser ignores bytes until the next byte flagged as track start.
module midi_track_event_parser
  import mtep_pkg::*;
#(
  parameter int unsigned MAX_QUANTITY_BYTES = MaxQuantityBytes
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [7:0] input_byte
  input  logic [7:0]   s_axis_tdata_i,
  // [0] track_start
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [27:0] delta_ticks, [35:28] status_byte, [43:36] data_first, [51:44] data_second,
  // [83:52] tempo_us, [91:84] beat_numerator, [99:92] beat_denominator_log2, [103:100] zero
  output logic [103:0] m_axis_tdata_o,
  // [2:0] event_kind, [3] used_running_status
  output logic [3:0]   m_axis_tuser_o
);

  localparam int unsigned CntW = 3;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_QUANTITY_BYTES);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       advance;
  logic       process;

  parse_phase_e             phase_q, phase_d, ph;
  logic [QuantityWidth-1:0] qacc_q, qacc_d, qacc;
  logic [CntW-1:0]          qcnt_q, qcnt_d, qcnt;
  logic [QuantityWidth-1:0] delta_q, delta_d, delta;
  logic [7:0]               rs_q, rs_d, rs;
  logic [7:0]               fd_q, fd_d, fd;
  logic [7:0]               mt_q, mt_d, mt;
  logic [QuantityWidth-1:0] mrem_q, mrem_d, mrem;
  logic [1:0]               midx_q, midx_d, midx;
  logic                     run_q, run_d, run;
  logic [TempoWidth-1:0]    tempo_q, tempo_d;
  logic [7:0]               num_q, num_d;
  logic [7:0]               den_q, den_d;

  logic [QuantityWidth-1:0] qval;
  logic [CntW-1:0]          qinc;
  logic                     qmore;
  logic                     qovf;
  logic [QuantityWidth-1:0] mrem_dec;

  logic                     emit;
  event_kind_e              e_kind;
  logic [QuantityWidth-1:0] e_delta;
  logic [7:0]               e_status;
  logic [7:0]               e_d1;
  logic [7:0]               e_d2;
  logic                     e_run;
  event_kind_e              meta_kind;

  logic                     out_valid_q;
  event_kind_e              out_kind_q;
  logic [QuantityWidth-1:0] out_delta_q;
  logic [7:0]               out_status_q;
  logic [7:0]               out_d1_q;
  logic [7:0]               out_d2_q;
  logic [TempoWidth-1:0]    out_tempo_q;
  logic [7:0]               out_num_q;
  logic [7:0]               out_den_q;
  logic                     out_run_q;

  assign advance = !out_valid_q || m_axis_tready_i;
  assign process = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
    end
  end

  always_comb begin
    ph = in_start_q ? PH_DELTA : phase_q;
    qacc = in_start_q ? '0 : qacc_q;
    qcnt = in_start_q ? '0 : qcnt_q;
    delta = in_start_q ? '0 : delta_q;
    rs = in_start_q ? '0 : rs_q;
    fd = in_start_q ? '0 : fd_q;
    mt = in_start_q ? '0 : mt_q;
    mrem = in_start_q ? '0 : mrem_q;
    midx = in_start_q ? '0 : midx_q;
    run = in_start_q ? 1'b0 : run_q;

    qval = {qacc[QuantityWidth-8:0], in_byte_q[6:0]};
    qinc = qcnt + CntW'(1);
    qmore = in_byte_q[7];
    qovf = qmore && (qinc >= MaxCnt);
    mrem_dec = mrem - QuantityWidth'(1);

    phase_d = ph;
    qacc_d = qacc;
    qcnt_d = qcnt;
    delta_d = delta;
    rs_d = rs;
    fd_d = fd;
    mt_d = mt;
    mrem_d = mrem;
    midx_d = midx;
    run_d = run;
    tempo_d = tempo_q;
    num_d = num_q;
    den_d = den_q;

    meta_kind = (mt == MetaTempo) ? EV_TEMPO :
                (mt == MetaTimeSignature) ? EV_TIME_SIG : EV_OTHER_META;

    emit = 1'b0;
    e_kind = EV_CHANNEL;
    e_delta = delta;
    e_status = 8'h00;
    e_d1 = 8'h00;
    e_d2 = 8'h00;
    e_run = 1'b0;

    unique case (ph)
      PH_DELTA: begin
        if (qmore && !qovf) begin
          qacc_d = qval;
          qcnt_d = qinc;
        end else begin
          delta_d = qval;
          e_delta = qval;
          qacc_d = '0;
          qcnt_d = '0;
          if (qovf) begin
            emit = 1'b1;
            e_kind = EV_LENGTH_OVERFLOW;
          end else begin
            phase_d = PH_STATUS;
          end
        end
      end
      PH_STATUS: begin
        if (in_byte_q == StatusMetaPrefix) begin
          phase_d = PH_MTYPE;
        end else if (in_byte_q <= DataMask) begin
          if (rs < ChannelStatusLow || rs > ChannelStatusHigh) begin
            phase_d = PH_DELTA;
            emit = 1'b1;
            e_kind = EV_UNKNOWN_STATUS;
            e_status = in_byte_q;
          end else if (is_one_data(rs)) begin
            phase_d = PH_DELTA;
            emit = 1'b1;
            e_status = rs;
            e_d1 = in_byte_q;
            e_run = 1'b1;
          end else begin
            fd_d = in_byte_q;
            run_d = 1'b1;
            phase_d = PH_DATA2;
          end
        end else if (in_byte_q <= ChannelStatusHigh) begin
          rs_d = in_byte_q;
          run_d = 1'b0;
          phase_d = PH_DATA1;
        end else begin
          phase_d = PH_DELTA;
          emit = 1'b1;
          e_kind = EV_UNKNOWN_STATUS;
          e_status = in_byte_q;
        end
      end
      PH_DATA1: begin
        if (is_one_data(rs)) begin
          phase_d = PH_DELTA;
          emit = 1'b1;
          e_status = rs;
          e_d1 = in_byte_q;
        end else begin
          fd_d = in_byte_q;
          phase_d = PH_DATA2;
        end
      end
      PH_DATA2: begin
        phase_d = PH_DELTA;
        emit = 1'b1;
        e_status = rs;
        e_d1 = fd;
        e_d2 = in_byte_q;
        e_run = run;
      end
      PH_MTYPE: begin
        mt_d = in_byte_q;
        qacc_d = '0;
        qcnt_d = '0;
        phase_d = PH_MLEN;
      end
      PH_MLEN: begin
        if (qmore && !qovf) begin
          qacc_d = qval;
          qcnt_d = qinc;
        end else begin
          mrem_d = qval;
          qacc_d = '0;
          qcnt_d = '0;
          if (qovf) begin
            phase_d = PH_DELTA;
            emit = 1'b1;
            e_kind = EV_LENGTH_OVERFLOW;
            e_status = mt;
          end else begin
            midx_d = '0;
            if (mt == MetaEndOfTrack) begin
              phase_d = PH_DONE;
              emit = 1'b1;
              e_kind = EV_END_OF_TRACK;
              e_status = MetaEndOfTrack;
            end else begin
              if (mt == MetaTempo) begin
                tempo_d = '0;
              end
              if (qval == '0) begin
                phase_d = PH_DELTA;
                emit = 1'b1;
                e_kind = meta_kind;
                e_status = mt;
              end else begin
                phase_d = PH_MBODY;
              end
            end
          end
        end
      end
      PH_MBODY: begin
        if (mt == MetaTempo) begin
          tempo_d = {tempo_q[TempoWidth-9:0], in_byte_q};
        end else if (mt == MetaTimeSignature) begin
          if (midx == 2'd0) begin
            num_d = in_byte_q;
          end else if (midx == 2'd1) begin
            den_d = in_byte_q;
          end
        end
        if (midx != 2'd3) begin
          midx_d = midx + 2'd1;
        end
        mrem_d = mrem_dec;
        if (mrem_dec == '0) begin
          phase_d = PH_DELTA;
          emit = 1'b1;
          e_kind = meta_kind;
          e_status = mt;
        end
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DELTA;
      qacc_q <= '0;
      qcnt_q <= '0;
      delta_q <= '0;
      rs_q <= '0;
      fd_q <= '0;
      mt_q <= '0;
      mrem_q <= '0;
      midx_q <= '0;
      run_q <= 1'b0;
      tempo_q <= '0;
      num_q <= '0;
      den_q <= '0;
    end else if (process) begin
      phase_q <= phase_d;
      qacc_q <= qacc_d;
      qcnt_q <= qcnt_d;
      delta_q <= delta_d;
      rs_q <= rs_d;
      fd_q <= fd_d;
      mt_q <= mt_d;
      mrem_q <= mrem_d;
      midx_q <= midx_d;
      run_q <= run_d;
      tempo_q <= tempo_d;
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= process && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && emit) begin
      out_kind_q <= e_kind;
      out_delta_q <= e_delta;
      out_status_q <= e_status;
      out_d1_q <= e_d1;
      out_d2_q <= e_d2;
      out_tempo_q <= tempo_d;
      out_num_q <= num_d;
      out_den_q <= den_d;
      out_run_q <= e_run;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = {4'h0, out_den_q, out_num_q, out_tempo_q, out_d2_q, out_d1_q,
                           out_status_q, out_delta_q};
  assign m_axis_tuser_o = {out_run_q, out_kind_q};

  a_qcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q < MaxCnt)
    else $error("quantity byte count reached its limit without an overflow record");

  a_running_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rs_q == 8'h00) || ((rs_q >= ChannelStatusLow) && (rs_q <= ChannelStatusHigh)))
    else $error("running status holds a byte that is not a channel status");

  a_eot_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && emit && (e_kind == EV_END_OF_TRACK)) |=> (phase_q == PH_DONE))
    else $error("parser did not stop after end of track");

  a_run_only_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_run_q) |-> (out_kind_q == EV_CHANNEL))
    else $error("running status flag set on a record that is not a channel message");

endmodule

### tb/sv/midi_track_event_checker.sv
// Record checker for the MIDI track event parser: predicts event records from accepted
// track bytes and compares them with the records leaving the output stream.
// Depends on mtep_pkg for the phase and kind types and the track byte codes.
module midi_track_event_checker
  import mtep_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  logic [7:0]   in_byte_i,
  input  logic         in_start_i,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic [103:0] out_data_i,
  input  logic [3:0]   out_user_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    event_kind_e kind;
    logic [27:0] delta;
    logic [7:0]  status;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [31:0] tempo;
    logic [7:0]  numer;
    logic [7:0]  denom;
    logic        running;
  } midi_record_t;

  typedef enum logic [1:0] {
    VLQ_MORE,
    VLQ_DONE,
    VLQ_OVERFLOW
  } vlq_step_e;

  midi_record_t awaited_events[$];

  parse_phase_e phase;
  logic [27:0]  qty_accum;
  logic [2:0]   qty_count;
  logic [27:0]  delta_hold;
  logic [7:0]   run_status;
  logic [7:0]   first_data;
  logic [7:0]   meta_type;
  logic [27:0]  meta_left;
  logic [1:0]   meta_idx;
  logic [31:0]  tempo;
  logic [7:0]   numer;
  logic [7:0]   denom;
  logic         run_flag;

  function automatic string describe(midi_record_t r);
    return $sformatf("kind %0d delta %h status %h data %h %h tempo %h sig %h/%h running %b",
                     r.kind, r.delta, r.status, r.data1, r.data2, r.tempo, r.numer, r.denom,
                     r.running);
  endfunction

  function automatic midi_record_t make_record(event_kind_e kind, logic [7:0] status,
                                               logic [7:0] d1, logic [7:0] d2,
                                               logic running);
    midi_record_t r;
    r.kind = kind;
    r.delta = delta_hold;
    r.status = status;
    r.data1 = d1;
    r.data2 = d2;
    r.tempo = tempo;
    r.numer = numer;
    r.denom = denom;
    r.running = running;
    return r;
  endfunction

  function automatic void clear_track();
    phase = PH_DELTA;
    qty_accum = '0;
    qty_count = '0;
    delta_hold = '0;
    run_status = '0;
    first_data = '0;
    meta_type = '0;
    meta_left = '0;
    meta_idx = '0;
    run_flag = 1'b0;
  endfunction

  function automatic vlq_step_e take_vlq_byte(logic [7:0] b);
    qty_accum = {qty_accum[20:0], b[6:0]};
    qty_count = qty_count + 3'd1;
    if (!b[7]) return VLQ_DONE;
    if (qty_count >= MaxQuantityBytes) return VLQ_OVERFLOW;
    return VLQ_MORE;
  endfunction

  function automatic void close_meta();
    event_kind_e kind;
    kind = (meta_type == MetaTempo) ? EV_TEMPO :
           (meta_type == MetaTimeSignature) ? EV_TIME_SIG : EV_OTHER_META;
    phase = PH_DELTA;
    awaited_events.push_back(make_record(kind, meta_type, 8'h00, 8'h00, 1'b0));
  endfunction

  task automatic parse_track_byte(input logic [7:0] b, input logic start);
    vlq_step_e step;
    if (start) clear_track();
    case (phase)
      PH_DELTA: begin
        step = take_vlq_byte(b);
        if (step != VLQ_MORE) begin
          delta_hold = qty_accum;
          qty_accum = '0;
          qty_count = '0;
          if (step == VLQ_OVERFLOW) begin
            awaited_events.push_back(make_record(EV_LENGTH_OVERFLOW, 8'h00, 8'h00, 8'h00,
                                                 1'b0));
          end else begin
            phase = PH_STATUS;
          end
        end
      end
      PH_STATUS: begin
        if (b == StatusMetaPrefix) begin
          phase = PH_MTYPE;
        end else if (!b[7]) begin
          if (run_status < ChannelStatusLow || run_status > ChannelStatusHigh) begin
            phase = PH_DELTA;
            awaited_events.push_back(make_record(EV_UNKNOWN_STATUS, b, 8'h00, 8'h00, 1'b0));
          end else if (run_status >= OneDataLow && run_status <= OneDataHigh) begin
            phase = PH_DELTA;
            awaited_events.push_back(make_record(EV_CHANNEL, run_status, b, 8'h00, 1'b1));
          end else begin
            first_data = b;
            run_flag = 1'b1;
            phase = PH_DATA2;
          end
        end else if (b <= ChannelStatusHigh) begin
          run_status = b;
          run_flag = 1'b0;
          phase = PH_DATA1;
        end else begin
          phase = PH_DELTA;
          awaited_events.push_back(make_record(EV_UNKNOWN_STATUS, b, 8'h00, 8'h00, 1'b0));
        end
      end
      PH_DATA1: begin
        if (run_status >= OneDataLow && run_status <= OneDataHigh) begin
          phase = PH_DELTA;
          awaited_events.push_back(make_record(EV_CHANNEL, run_status, b, 8'h00, 1'b0));
        end else begin
          first_data = b;
          phase = PH_DATA2;
        end
      end
      PH_DATA2: begin
        phase = PH_DELTA;
        awaited_events.push_back(make_record(EV_CHANNEL, run_status, first_data, b,
                                             run_flag));
      end
      PH_MTYPE: begin
        meta_type = b;
        qty_accum = '0;
        qty_count = '0;
        phase = PH_MLEN;
      end
      PH_MLEN: begin
        step = take_vlq_byte(b);
        if (step != VLQ_MORE) begin
          meta_left = qty_accum;
          qty_accum = '0;
          qty_count = '0;
          if (step == VLQ_OVERFLOW) begin
            phase = PH_DELTA;
            awaited_events.push_back(make_record(EV_LENGTH_OVERFLOW, meta_type, 8'h00, 8'h00,
                                                 1'b0));
          end else begin
            meta_idx = '0;
            if (meta_type == MetaEndOfTrack) begin
              phase = PH_DONE;
              awaited_events.push_back(make_record(EV_END_OF_TRACK, MetaEndOfTrack, 8'h00,
                                                   8'h00, 1'b0));
            end else begin
              if (meta_type == MetaTempo) tempo = '0;
              if (meta_left == '0) close_meta();
              else phase = PH_MBODY;
            end
          end
        end
      end
      PH_MBODY: begin
        if (meta_type == MetaTempo) begin
          tempo = {tempo[23:0], b};
        end else if (meta_type == MetaTimeSignature) begin
          if (meta_idx == 2'd0) numer = b;
          else if (meta_idx == 2'd1) denom = b;
        end
        if (meta_idx < 2'd3) meta_idx = meta_idx + 2'd1;
        meta_left = meta_left - 28'd1;
        if (meta_left == '0) close_meta();
      end
      default: begin
        phase = PH_DONE;
      end
    endcase
  endtask

  task automatic check_record();
    midi_record_t want;
    midi_record_t got;
    got.kind = event_kind_e'(out_user_i[2:0]);
    got.running = out_user_i[3];
    got.delta = out_data_i[27:0];
    got.status = out_data_i[35:28];
    got.data1 = out_data_i[43:36];
    got.data2 = out_data_i[51:44];
    got.tempo = out_data_i[83:52];
    got.numer = out_data_i[91:84];
    got.denom = out_data_i[99:92];
    if (awaited_events.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) $display("Unexpected record: %s", describe(got));
      return;
    end
    want = awaited_events.pop_front();
    if (got.kind !== want.kind || got.delta !== want.delta || got.status !== want.status ||
        got.data1 !== want.data1 || got.data2 !== want.data2 || got.tempo !== want.tempo ||
        got.numer !== want.numer || got.denom !== want.denom ||
        got.running !== want.running || out_data_i[103:100] !== 4'h0) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("Record mismatch at %0t: expected %s", $realtime, describe(want));
        $display("  actual %s pad %h", describe(got), out_data_i[103:100]);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_track();
      tempo = '0;
      numer = '0;
      denom = '0;
      awaited_events.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_record();
      if (in_valid_i && in_ready_i) parse_track_byte(in_byte_i, in_start_i);
    end
    pending_o = awaited_events.size();
  end

endmodule

### tb/sv/tb_midi_track_event_parser.sv
// Top of the MIDI track event parser bench: drives track bytes and output stalls, and
// gives the verdict. Depends on mtep_pkg, midi_track_event_parser and
// midi_track_event_checker.
module tb_midi_track_event_parser
  import mtep_pkg::*;
();

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [7:0]   s_data = 8'h00;
  logic         s_user = 1'b0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [103:0] m_data;
  logic [3:0]   m_user;

  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   bytes_sent = 0;
  logic next_start = 1'b0;
  logic [7:0] tx_status = 8'h00;
  logic rx_hold_req = 1'b0;
  logic rx_hold_done = 1'b0;

  midi_track_event_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  midi_track_event_checker event_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_byte_i    (s_data),
    .in_start_i   (s_user),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .out_user_i   (m_user),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #1600000;
    $display("*** FAILED ***");
    $finish;
  end

  // The receiver takes one long hold-off when asked, otherwise it stalls at random.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req && !rx_hold_done) begin
        m_ready <= 1'b0;
        for (int n = 0; n < 300; n++) @(posedge clk_i);
        rx_hold_done = 1'b1;
      end else begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= b;
    s_user <= next_start;
    if (next_start) tx_status = 8'h00;
    next_start = 1'b0;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_data();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                                         8'($urandom_range(0, 127));
  endfunction

  task automatic send_vlq(input logic [27:0] value, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) begin
      logic [27:0] chunk;
      chunk = value >> (7 * i);
      send_byte({(i != 0), chunk[6:0]});
    end
  endtask

  task automatic send_overlong_vlq();
    repeat (4) send_byte({1'b1, 7'($urandom_range(0, 127))});
  endtask

  task automatic send_delta(output logic overflow);
    int nbytes;
    logic [27:0] value;
    overflow = ($urandom_range(0, 99) < 4);
    if (overflow) begin
      send_overlong_vlq();
    end else begin
      nbytes = ($urandom_range(0, 99) < 70) ? 1 : $urandom_range(2, 4);
      value = 28'($urandom()) & ((28'd1 << (7 * nbytes)) - 28'd1);
      send_vlq(value, nbytes);
    end
  endtask

  task automatic send_meta(input logic [7:0] mtype, input int len);
    int r;
    send_byte(StatusMetaPrefix);
    send_byte(mtype);
    r = $urandom_range(0, 99);
    if (r < 3) begin
      send_overlong_vlq();
      return;
    end
    if (r < 10) send_vlq(28'(len), 2);
    else send_vlq(28'(len), 1);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
    if (mtype == MetaEndOfTrack) begin
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
      next_start = 1'b1;
    end
  endtask

  task automatic send_random_event();
    logic overflow;
    int pick;
    int r;
    logic [7:0] status;
    if ($urandom_range(0, 99) < 4) next_start = 1'b1;
    send_delta(overflow);
    if (overflow) return;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      status = 8'($urandom_range(ChannelStatusLow, ChannelStatusHigh));
      send_byte(status);
      tx_status = status;
      send_byte(pick_data());
      if (!(status >= OneDataLow && status <= OneDataHigh)) send_byte(pick_data());
    end else if (pick < 65) begin
      send_byte(8'($urandom_range(0, 127)));
      if (tx_status >= ChannelStatusLow &&
          !(tx_status >= OneDataLow && tx_status <= OneDataHigh)) begin
        send_byte(pick_data());
      end
    end else if (pick < 88) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_meta(MetaTempo, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 3);
      end else if (r < 55) begin
        send_meta(MetaTimeSignature,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 4);
      end else if (r < 65) begin
        send_meta(MetaEndOfTrack, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      end else begin
        send_meta(8'($urandom_range(0, 255)), $urandom_range(0, 5));
      end
    end else if (pick < 94) begin
      send_byte(8'($urandom_range(8'hF0, 8'hFE)));
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [7:0] first_track[$] = '{
      8'h00, 8'h90, 8'h00, 8'h7F,
      8'h00, 8'h40, 8'hFF,
      8'h00, 8'hC3, 8'h80,
      8'h00, 8'hF0,
      8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'h7F, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20,
      8'h00, 8'hFF, 8'h58, 8'h02, 8'h06, 8'h03,
      8'h81, 8'h00, 8'hFF, 8'h2F, 8'h00,
      8'h11
    };
    int idle_plan[4][2] = '{'{0, 0}, '{53, 0}, '{0, 53}, '{7, 7}};
    int target;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    next_start = 1'b1;
    foreach (first_track[i]) send_byte(first_track[i]);
    next_start = 1'b1;
    send_byte(8'h00);
    send_byte(8'h10);
    s_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p][0];
      recv_stall_pct = idle_plan[p][1];
      if (p == 0) rx_hold_req <= 1'b1;
      target = bytes_sent + 175;
      while (bytes_sent < target) send_random_event();
      s_valid <= 1'b0;
      @(posedge clk_i);
      wait (pending == 0);
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
